// ===== rtl/tpep_pkg.sv =====
// shared types, constants and a helper function of the timed pin event player
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package tpep_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_OUT         = 64;
    localparam int OUT_CNT_W       = $clog2(MAX_OUT + 1);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
    localparam logic [1:0]  ANALOG_CODE_RST = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ANALOG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT3  = 3'd4;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_FULL   = 2'd1,
        ST_LATE   = 2'd2,
        ST_UPDATE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_CMP,
        S_RESP,
        S_PL_RD,
        S_PL_CMP,
        S_PL_END
    } state_t;

    // one stored event
    typedef struct packed {
        logic [31:0] ev_time;
        logic [1:0]  ev_field;
        logic [4:0]  ev_pin;
        logic [15:0] ev_value;
    } evt_entry_t;

    typedef struct packed {
        logic    capture;
        logic    ld_init;
        logic    rd_ld;
        logic    shift;
        logic    wr_new;
        logic    set_resp;
        status_t resp;
        logic    emit_resp;
        logic    tick_start;
        logic    rd_pl;
        logic    play;
        logic    emit_pend;
        logic    emit_last;
        logic    time_inc;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic full;
        logic j_zero;
        logic ld_ge;
        logic pos_ok;
        logic n_ok;
        logic due;
        logic pend_valid;
        logic out_free;
    } sts_t;

    // index of the lowest set bit, zero for an empty mask
    function automatic logic [4:0] lowest_pin(input logic [31:0] mask);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tpep_ctrl.sv =====
// sequencer of the timed pin event player: sorted insert and tick playback
// depends on tpep_pkg; drives tpep_dpath through cmd_t and reads sts_t
`default_nettype none

module tpep_ctrl
    import tpep_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic action,
    input  wire sts_t sts,
    output logic      in_stall,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.resp   = ST_LOADED;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!action)
                    begin
                        cmd.capture  = 1'b1;
                        cmd.set_resp = 1'b1;
                        if (sts.started)
                        begin
                            cmd.resp   = ST_LATE;
                            state_next = S_RESP;
                        end
                        else if (sts.full)
                        begin
                            cmd.resp   = ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.resp    = ST_LOADED;
                            cmd.ld_init = 1'b1;
                            state_next  = S_LD_RD;
                        end
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_PL_RD;
                    end
                end
            end
            S_LD_RD:
            begin
                if (sts.j_zero)
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_ld  = 1'b1;
                    state_next = S_LD_CMP;
                end
            end
            S_LD_CMP:
            begin
                // entries at or after the new time move up one slot
                if (sts.ld_ge)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_LD_RD;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_resp = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PL_RD:
            begin
                if (sts.n_ok && sts.pos_ok)
                begin
                    cmd.rd_pl  = 1'b1;
                    state_next = S_PL_CMP;
                end
                else
                begin
                    state_next = S_PL_END;
                end
            end
            S_PL_CMP:
            begin
                // the held result goes out only once we know another follows
                if (sts.due)
                begin
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.play      = 1'b1;
                        cmd.emit_pend = sts.pend_valid;
                        state_next    = S_PL_RD;
                    end
                end
                else
                begin
                    state_next = S_PL_END;
                end
            end
            S_PL_END:
            begin
                if (sts.pend_valid)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_pend = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.time_inc  = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.time_inc = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tpep_dpath.sv =====
// datapath of the timed pin event player: event memory, pointers, field
// registers, config registers and output register; depends on tpep_pkg
`default_nettype none

module tpep_dpath
    import tpep_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [31:0]           event_time,
    input  wire logic [1:0]            event_field,
    input  wire logic [31:0]           event_pin_mask,
    input  wire logic [15:0]           event_value,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [1:0]                 status,
    output logic [1:0]                 field_code,
    output logic [31:0]                field_value,
    output logic                       last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    evt_entry_t evt_mem [DEPTH];
    evt_entry_t rd_data_reg;
    evt_entry_t new_reg;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        j_reg;
    logic [CW-1:0]        pos_reg;
    logic [OUT_CNT_W-1:0] n_reg;
    logic [31:0]          cur_time_reg;
    logic                 started_reg;
    status_t              resp_reg;

    logic [1:0]  analog_code_reg;
    logic [31:0] fld_reg  [4];

    logic        pend_valid_reg;
    logic [1:0]  pend_code_reg;
    logic [31:0] pend_value_reg;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [1:0]  out_code_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;

    logic [CW-1:0] j_dec;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    evt_entry_t    wr_data;
    logic          out_free;
    logic          cfg_init_hit;
    logic [1:0]    cfg_init_sel;
    logic [31:0]   play_bit;
    logic [31:0]   play_value;

    assign j_dec   = j_reg - CW'(1);
    assign rd_addr = cmd.rd_pl ? pos_reg[AW-1:0] : j_dec[AW-1:0];
    assign wr_addr = j_reg[AW-1:0];
    assign wr_data = cmd.shift ? rd_data_reg : new_reg;

    // event memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.shift || cmd.wr_new)
        begin
            evt_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_ld || cmd.rd_pl)
        begin
            rd_data_reg <= evt_mem[rd_addr];
        end
        if (cmd.capture)
        begin
            new_reg.ev_time  <= event_time;
            new_reg.ev_field <= event_field;
            new_reg.ev_pin   <= lowest_pin(event_pin_mask);
            new_reg.ev_value <= event_value;
        end
    end

    // new value of the field addressed by the event just read
    always_comb
    begin
        play_bit = 32'd1 << rd_data_reg.ev_pin;
        if (rd_data_reg.ev_field == analog_code_reg)
        begin
            play_value = {16'd0, rd_data_reg.ev_value};
        end
        else if (rd_data_reg.ev_value != 16'd0)
        begin
            play_value = fld_reg[rd_data_reg.ev_field] | play_bit;
        end
        else
        begin
            play_value = fld_reg[rd_data_reg.ev_field] & ~play_bit;
        end
    end

    always_comb
    begin
        cfg_init_hit = 1'b0;
        cfg_init_sel = 2'd0;
        case (cfg_index)
            CFG_INIT0:
            begin
                cfg_init_hit = 1'b1;
                cfg_init_sel = 2'd0;
            end
            CFG_INIT1:
            begin
                cfg_init_hit = 1'b1;
                cfg_init_sel = 2'd1;
            end
            CFG_INIT2:
            begin
                cfg_init_hit = 1'b1;
                cfg_init_sel = 2'd2;
            end
            CFG_INIT3:
            begin
                cfg_init_hit = 1'b1;
                cfg_init_sel = 2'd3;
            end
            default:
            begin
                cfg_init_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            analog_code_reg <= ANALOG_CODE_RST;
            for (int k = 0; k < 4; k++)
            begin
                fld_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_ANALOG)
            begin
                analog_code_reg <= cfg_data[1:0];
            end
            // init registers have no read-back, so only the field copy is kept
            if (cfg_we && cfg_init_hit && !started_reg)
            begin
                fld_reg[cfg_init_sel] <= cfg_data;
            end
            if (cmd.play)
            begin
                fld_reg[rd_data_reg.ev_field] <= play_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            j_reg          <= '0;
            pos_reg        <= '0;
            n_reg          <= '0;
            cur_time_reg   <= '0;
            started_reg    <= 1'b0;
            resp_reg       <= ST_LOADED;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_resp)
            begin
                resp_reg <= cmd.resp;
            end
            if (cmd.ld_init)
            begin
                j_reg <= count_reg;
            end
            else if (cmd.shift)
            begin
                j_reg <= j_dec;
            end
            if (cmd.wr_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.tick_start)
            begin
                started_reg <= 1'b1;
                n_reg       <= '0;
            end
            else if (cmd.play)
            begin
                n_reg <= n_reg + OUT_CNT_W'(1);
            end
            if (cmd.play)
            begin
                pos_reg        <= pos_reg + CW'(1);
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.time_inc && cur_time_reg != TIME_MAX)
            begin
                cur_time_reg <= cur_time_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.play)
        begin
            pend_code_reg  <= rd_data_reg.ev_field;
            pend_value_reg <= play_value;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_resp || cmd.emit_pend)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_resp)
        begin
            out_status_reg <= resp_reg;
            out_code_reg   <= 2'd0;
            out_value_reg  <= 32'd0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_pend)
        begin
            out_status_reg <= ST_UPDATE;
            out_code_reg   <= pend_code_reg;
            out_value_reg  <= pend_value_reg;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign field_code  = out_code_reg;
    assign field_value = out_value_reg;
    assign last        = out_last_reg;

    assign sts.started    = started_reg;
    assign sts.full       = (count_reg == CW'(DEPTH));
    assign sts.j_zero     = (j_reg == '0);
    assign sts.ld_ge      = (rd_data_reg.ev_time >= new_reg.ev_time);
    assign sts.pos_ok     = (pos_reg < count_reg);
    assign sts.n_ok       = (n_reg < OUT_CNT_W'(MAX_OUT));
    assign sts.due        = (rd_data_reg.ev_time <= cur_time_reg);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

endmodule

`default_nettype wire

// ===== rtl/timed_pin_event_player.sv =====
// timed pin event player: takes one item at a time and holds in_stall until it is done
// a load moves each stored entry with an equal or later time up one slot, one at a time
// through the single memory read port; a full or late load only sends its response
// a tick plays due events in time order, at most 64, up to the first one not yet due
// an output stall holds a waiting result until the receiver takes it
// reset clears pointers, count, time, start flag, field and config registers; no clearing pass
`default_nettype none

module timed_pin_event_player
    import tpep_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  action,
    input  wire logic [31:0]           event_time,
    input  wire logic [1:0]            event_field,
    input  wire logic [31:0]           event_pin_mask,
    input  wire logic [15:0]           event_value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 status,
    output logic [1:0]                 field_code,
    output logic [31:0]                field_value,
    output logic                       last
);

    cmd_t cmd;
    sts_t sts;

    tpep_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    tpep_dpath #(
        .DEPTH (TABLE_DEPTH)
    ) u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .event_time     (event_time),
        .event_field    (event_field),
        .event_pin_mask (event_pin_mask),
        .event_value    (event_value),
        .cmd            (cmd),
        .sts            (sts),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .field_code     (field_code),
        .field_value    (field_value),
        .last           (last)
    );

endmodule

`default_nettype wire

// ===== dv/timed_pin_event_player_tb.sv =====
// self-checking testbench for timed_pin_event_player: sorted loads, full table,
// late loads and tick playback, each checked against a predictor kept in the bench
// depends on rtl/tpep_pkg.sv and rtl/timed_pin_event_player.sv
module timed_pin_event_player_tb;
    import tpep_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam bit ACT_LOAD       = 1'b0;
    localparam bit ACT_TICK       = 1'b1;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        bit          action;
        logic [31:0] ev_time;
        logic [1:0]  field;
        logic [31:0] mask;
        logic [15:0] value;
    } player_item_t;

    typedef struct {
        status_t     st;
        logic [1:0]  code;
        logic [31:0] value;
        bit          last;
    } field_update_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic [31:0]           event_time;
    logic [1:0]            event_field;
    logic [31:0]           event_pin_mask;
    logic [15:0]           event_value;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [1:0]            field_code;
    logic [31:0]           field_value;
    logic                  last;

    // predicted player state
    evt_entry_t    schedule[DEPTH];
    int            sched_count;
    int            play_idx;
    logic [31:0]   now_ticks;
    bit            running;
    logic [31:0]   field_reg[4];
    logic [1:0]    analog_code;
    field_update_t expected_updates[$];

    int error_count = 0;
    int quiet_cycles = 0;
    bit tx_gaps = 1'b1;
    bit rx_quiet = 1'b0;

    timed_pin_event_player #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .event_time     (event_time),
        .event_field    (event_field),
        .event_pin_mask (event_pin_mask),
        .event_value    (event_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .field_code     (field_code),
        .field_value    (field_value),
        .last           (last)
    );

    always #5 clk = ~clk;

    function automatic logic [4:0] pin_of(input logic [31:0] mask);
        for (int i = 0; i < 32; i++)
        begin
            if (mask[i])
            begin
                return 5'(i);
            end
        end
        return 5'd0;
    endfunction

    function automatic void push_update(input status_t st, input logic [1:0] code,
                                        input logic [31:0] value, input bit is_last);
        field_update_t u;
        u.st = st;
        u.code = code;
        u.value = value;
        u.last = is_last;
        expected_updates.insert(expected_updates.size(), u);
    endfunction

    function automatic void predict_item(input player_item_t it);
        int         pos;
        int         n;
        logic [1:0] f;
        logic [4:0] pin;
        if (it.action == ACT_LOAD)
        begin
            if (running)
            begin
                push_update(ST_LATE, 2'd0, 32'd0, 1'b1);
            end
            else if (sched_count >= DEPTH)
            begin
                push_update(ST_FULL, 2'd0, 32'd0, 1'b1);
            end
            else
            begin
                // goes ahead of the first entry with an equal or later time
                pos = sched_count;
                for (int j = 0; j < sched_count; j++)
                begin
                    if (schedule[j].ev_time >= it.ev_time)
                    begin
                        pos = j;
                        break;
                    end
                end
                for (int j = sched_count; j > pos; j--)
                begin
                    schedule[j] = schedule[j - 1];
                end
                schedule[pos].ev_time = it.ev_time;
                schedule[pos].ev_field = it.field;
                schedule[pos].ev_pin = pin_of(it.mask);
                schedule[pos].ev_value = it.value;
                sched_count++;
                push_update(ST_LOADED, 2'd0, 32'd0, 1'b1);
            end
        end
        else
        begin
            running = 1'b1;
            n = 0;
            while (n < MAX_OUT && play_idx < sched_count
                   && schedule[play_idx].ev_time <= now_ticks)
            begin
                f = schedule[play_idx].ev_field;
                pin = schedule[play_idx].ev_pin;
                if (f == analog_code)
                begin
                    field_reg[f] = 32'(schedule[play_idx].ev_value);
                end
                else
                begin
                    field_reg[f][pin] = (schedule[play_idx].ev_value != 16'd0);
                end
                push_update(ST_UPDATE, f, field_reg[f], 1'b0);
                n++;
                play_idx++;
            end
            if (n > 0)
            begin
                expected_updates[expected_updates.size() - 1].last = 1'b1;
            end
            if (now_ticks != TIME_MAX)
            begin
                now_ticks++;
            end
        end
    endfunction

    function automatic player_item_t make_load(input logic [31:0] t, input logic [1:0] f,
                                               input logic [31:0] m, input logic [15:0] v);
        player_item_t it;
        it.action = ACT_LOAD;
        it.ev_time = t;
        it.field = f;
        it.mask = m;
        it.value = v;
        return it;
    endfunction

    // times mostly small unless wide_time is set, so that the events play within the run
    function automatic player_item_t rand_load(input bit wide_time);
        player_item_t it;
        int           r;
        it.action = ACT_LOAD;
        r = $urandom_range(0, 9);
        if (wide_time || r == 0)
        begin
            it.ev_time = $urandom();
        end
        else if (r < 4)
        begin
            it.ev_time = 32'd0;
        end
        else
        begin
            it.ev_time = $urandom_range(1, 250);
        end
        it.field = 2'($urandom());
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            it.mask = 32'd0;
        end
        else if (r == 1)
        begin
            it.mask = $urandom();
        end
        else
        begin
            it.mask = $urandom() << $urandom_range(0, 31);
        end
        it.value = ($urandom_range(0, 1) == 1) ? 16'($urandom()) : 16'd0;
        return it;
    endfunction

    function automatic player_item_t make_tick();
        player_item_t it;
        it = rand_load(1'b1);
        it.action = ACT_TICK;
        return it;
    endfunction

    task automatic send_item(input player_item_t it);
        int gap;
        gap = 0;
        if (tx_gaps && $urandom_range(0, 99) >= 65)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= it.action;
        event_time <= it.ev_time;
        event_field <= it.field;
        event_pin_mask <= it.mask;
        event_value <= it.value;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        int k;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ANALOG)
        begin
            analog_code = data[1:0];
        end
        else
        begin
            k = int'(idx - CFG_INIT0);
            if (!running)
            begin
                field_reg[k] = data;
            end
        end
    endtask

    // hold the sender until every result is in, then let a late tick finish
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_updates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_config_extremes();
        logic [31:0] pattern[4];
        pattern = '{32'hA5A5_5A5A, $urandom(), 32'h0000_FFFF, 32'hFFFF_0000};
        write_reg(CFG_ANALOG, 32'd0);
        for (int i = 0; i < 4; i++)
        begin
            write_reg(CFG_INIT0 + CFG_IDX_W'(i), 32'hFFFF_FFFF);
        end
        write_reg(CFG_ANALOG, 32'd3);
        for (int i = 0; i < 4; i++)
        begin
            write_reg(CFG_INIT0 + CFG_IDX_W'(i), 32'd0);
        end
        for (int i = 0; i < 4; i++)
        begin
            write_reg(CFG_INIT0 + CFG_IDX_W'(i), pattern[i]);
        end
        write_reg(CFG_ANALOG, 32'd2);
    endtask

    task automatic test_sorted_loads();
        send_item(make_load(32'd0, 2'd0, 32'd0, 16'd1));
        send_item(make_load(32'd0, 2'd1, 32'h8000_0000, 16'hFFFF));
        send_item(make_load(32'hFFFF_FFFF, 2'd2, 32'hFFFF_FFFF, 16'd0));
        send_item(make_load(32'd5, 2'd3, 32'h0001_0000, 16'h8000));
        // equal time lands ahead of the earlier one
        send_item(make_load(32'd5, 2'd0, 32'h0000_0006, 16'd0));
        send_item(make_load(32'd0, 2'd2, 32'h0000_0100, 16'h0001));
        send_item(make_load(32'd1, 2'd3, 32'd0, 16'd0));
        send_item(make_load(32'd2, 2'd1, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(make_load(32'h8000_0000, 2'd0, 32'h4000_0000, 16'h1234));
        send_item(make_load(32'd3, 2'd2, 32'h0000_0020, 16'd0));
        send_item(make_load(32'd0, 2'd3, 32'h0000_0004, 16'hFFFF));
        send_item(make_load(32'd0, 2'd0, 32'h8000_0000, 16'd0));
        send_item(make_load(32'd2, 2'd1, 32'h0000_0001, 16'd0));
        send_item(make_load(32'hFFFF_FFFE, 2'd3, 32'h5555_5554, 16'h7FFF));
    endtask

    task automatic test_fill_table();
        while (sched_count < DEPTH)
        begin
            send_item(rand_load(1'b0));
        end
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 6; i++)
        begin
            send_item(rand_load(1'b1));
        end
        wait_idle();
        // not started yet, so the field registers follow
        for (int i = 0; i < 4; i++)
        begin
            write_reg(CFG_INIT0 + CFG_IDX_W'(i), $urandom());
        end
        write_reg(CFG_ANALOG, 32'd1);
    endtask

    task automatic test_first_tick();
        send_item(make_tick());
    endtask

    task automatic test_playback();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            write_reg(CFG_ANALOG, 32'((phase + 3) % 4));
            // after the start this write leaves the field register unchanged
            write_reg(CFG_INIT0 + CFG_IDX_W'(phase), $urandom());
            tx_gaps = (phase != 1);
            rx_quiet = (phase == 2);
            for (int k = 0; k < 90; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_item(rand_load(1'b1));
                end
                else
                begin
                    send_item(make_tick());
                end
            end
        end
        rx_quiet = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        field_update_t want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            if (expected_updates.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, actual %0h/%0h/%0h/%0h",
                         $time, status, field_code, field_value, last);
                error_count++;
            end
            else
            begin
                want = expected_updates.pop_front();
                check_field("status", 32'(want.st), 32'(status));
                check_field("field_code", 32'(want.code), 32'(field_code));
                check_field("field_value", want.value, field_value);
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timed_pin_event_player_tb: done, errors");
                $finish;
            end
        end
    end

    // receiver: ready runs with short and occasional long stalls
    initial
    begin
        int run;
        bit hold;
        out_stall = 1'b0;
        forever
        begin
            hold = !rx_quiet && ($urandom_range(0, 2) == 0);
            if (!hold)
            begin
                run = $urandom_range(1, 24);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                run = $urandom_range(15, 40);
            end
            else
            begin
                run = $urandom_range(1, 3);
            end
            repeat (run)
            begin
                @(negedge clk);
                out_stall <= hold;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ANALOG;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_LOAD;
        event_time = '0;
        event_field = '0;
        event_pin_mask = '0;
        event_value = '0;
        sched_count = 0;
        play_idx = 0;
        now_ticks = '0;
        running = 1'b0;
        analog_code = ANALOG_CODE_RST;
        for (int i = 0; i < 4; i++)
        begin
            field_reg[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_config_extremes();
        test_sorted_loads();
        test_fill_table();
        test_full_table();
        test_first_tick();
        test_playback();

        wait_idle();
        if (error_count == 0)
        begin
            $display("timed_pin_event_player_tb: done, clean");
        end
        else
        begin
            $display("timed_pin_event_player_tb: done, errors");
        end
        $finish;
    end

endmodule
